FILE: rtl/core/hvn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_pkg
// Constants shared by the hashed value noise unit: register map, reset
// values, lattice hash multipliers and the reciprocal for the ppm divide.
// ----------------------------------------------------------------------------
package hvn_pkg;

  // configuration register map
  typedef enum logic [2:0] {
    CFG_FREQ_X = 3'd0,
    CFG_FREQ_Y = 3'd1,
    CFG_FLOW   = 3'd2,
    CFG_SEED   = 3'd3
  } cfg_reg_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned FREQ_W     = 20;
  localparam int unsigned FLOW_W     = 24;
  localparam int unsigned SEED_W     = 32;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned NOISE_W    = 8;

  localparam logic [FREQ_W-1:0] FREQ_RESET = 20'd10000;
  localparam logic [FLOW_W-1:0] FLOW_RESET = '0;
  localparam logic [SEED_W-1:0] SEED_RESET = '0;

  // lattice hash multipliers
  localparam logic [31:0] HASH_MUL_X    = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y    = 32'd668265263;
  localparam logic [31:0] HASH_MUL_SEED = 32'd2246822519;
  localparam logic [31:0] HASH_MUL_MIX  = 32'd1274126177;

  // coord * freq * 256 / 1e6 == 4 * coord * freq / 15625
  localparam logic [13:0] DIV_CONST = 14'd15625;
  localparam int unsigned RECIP_SHIFT = 40;
  // floor(2^40 * 32 / 15625), applied to the magnitude shifted right by three
  localparam logic [31:0] DIV_RECIP = 32'((64'd1 << 45) / 64'd15625);

  // smoothstep numerator constant
  localparam logic [9:0] EASE_K = 10'd768;

endpackage

FILE: rtl/core/hashed_value_noise_q8_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_value_noise_q8_unit
// 2-D value noise on a hashed integer lattice: ppm scaling to Q8, floor,
// smoothstep easing, four corner hashes and bilinear blend, 8-bit sample.
// ----------------------------------------------------------------------------
// pipeline: eleven register stages
// throughput: one request per cycle unless the output stalls; each stage moves on when it is empty or
//   the stage after it moves, so bubbles collapse under output stalls
// reset: empties the pipeline and loads the default frequencies, offset, seed
module hashed_value_noise_q8_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hvn_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [hvn_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [hvn_pkg::COORD_W-1:0]   screen_x_i,
  input  logic signed [hvn_pkg::COORD_W-1:0]   screen_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [hvn_pkg::NOISE_W-1:0]          noise_value_o
);

  localparam int unsigned NStg = 11;

  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] t);
    logic signed [8:0]  d;
    logic signed [17:0] p;
    logic signed [9:0]  sh;
    d  = $signed({1'b0, b}) - $signed({1'b0, a});
    p  = d * $signed({1'b0, t});
    sh = 10'(p >>> 8);
    return a + sh[7:0];
  endfunction

  // configuration registers
  logic [hvn_pkg::FREQ_W-1:0] freq_x_q, freq_y_q;
  logic [hvn_pkg::FLOW_W-1:0] flow_q;
  logic [hvn_pkg::SEED_W-1:0] seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_x_q <= hvn_pkg::FREQ_RESET;
      freq_y_q <= hvn_pkg::FREQ_RESET;
      flow_q   <= hvn_pkg::FLOW_RESET;
      seed_q   <= hvn_pkg::SEED_RESET;
    end else if (cfg_we_i) begin
      unique case (hvn_pkg::cfg_reg_e'(cfg_index_i))
        hvn_pkg::CFG_FREQ_X: freq_x_q <= cfg_wdata_i[hvn_pkg::FREQ_W-1:0];
        hvn_pkg::CFG_FREQ_Y: freq_y_q <= cfg_wdata_i[hvn_pkg::FREQ_W-1:0];
        hvn_pkg::CFG_FLOW:   flow_q   <= cfg_wdata_i[hvn_pkg::FLOW_W-1:0];
        hvn_pkg::CFG_SEED:   seed_q   <= cfg_wdata_i[hvn_pkg::SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic [NStg-1:0] v_q, en;

  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || out_ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o = en[0];

  // lane 0 is x, lane 1 is y
  logic signed [hvn_pkg::COORD_W-1:0] coord [2];
  logic [hvn_pkg::FREQ_W-1:0]         freq  [2];
  assign coord[0] = screen_x_i;
  assign coord[1] = screen_y_i;
  assign freq[0]  = freq_x_q;
  assign freq[1]  = freq_y_q;

  // stage 1: coord * freq
  logic signed [36:0] s1_full [2];
  logic        [35:0] s1_prod_q [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      s1_full[l] = coord[l] * $signed({1'b0, freq[l]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int l = 0; l < 2; l++) s1_prod_q[l] <= s1_full[l][35:0];
    end
  end

  // stage 2: magnitude and sign, divide truncates toward zero
  logic [35:0] s2_abs [2];
  logic [34:0] s2_mag_q [2];
  logic [1:0]  s2_neg_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      s2_abs[l] = s1_prod_q[l][35] ? (~s1_prod_q[l] + 36'd1) : s1_prod_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int l = 0; l < 2; l++) begin
        s2_mag_q[l] <= s2_abs[l][34:0];
        s2_neg_q[l] <= s1_prod_q[l][35];
      end
    end
  end

  // stage 3: reciprocal estimate, low by at most two
  logic [63:0] s3_est [2];
  logic [23:0] s3_q0_q [2];
  logic [13:0] s3_mag_lo_q [2];
  logic [1:0]  s3_neg_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      s3_est[l] = s2_mag_q[l][34:3] * hvn_pkg::DIV_RECIP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int l = 0; l < 2; l++) begin
        s3_q0_q[l]     <= s3_est[l][hvn_pkg::RECIP_SHIFT +: 24];
        s3_mag_lo_q[l] <= s2_mag_q[l][13:0];
      end
      s3_neg_q <= s2_neg_q;
    end
  end

  // stage 4: remainder, known to stay below three divisors
  logic [37:0] s4_back [2];
  logic [15:0] s4_rem [2];
  logic [15:0] s4_rem_q [2];
  logic [23:0] s4_q0_q [2];
  logic [1:0]  s4_neg_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      s4_back[l] = s3_q0_q[l] * hvn_pkg::DIV_CONST;
      s4_rem[l]  = {s3_mag_lo_q[l], 2'b00} - s4_back[l][15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int l = 0; l < 2; l++) begin
        s4_rem_q[l] <= s4_rem[l];
        s4_q0_q[l]  <= s3_q0_q[l];
      end
      s4_neg_q <= s3_neg_q;
    end
  end

  // stage 5: quotient correction
  logic [1:0]  s5_corr [2];
  logic [23:0] s5_q_q [2];
  logic [1:0]  s5_neg_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (s4_rem_q[l] >= {1'b0, hvn_pkg::DIV_CONST, 1'b0}) s5_corr[l] = 2'd2;
      else if (s4_rem_q[l] >= {2'b00, hvn_pkg::DIV_CONST}) s5_corr[l] = 2'd1;
      else s5_corr[l] = 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int l = 0; l < 2; l++) s5_q_q[l] <= s4_q0_q[l] + {22'd0, s5_corr[l]};
      s5_neg_q <= s4_neg_q;
    end
  end

  // stage 6: signed Q8 positions, flow offset taken off y
  logic [24:0] s6_sq [2];
  logic [25:0] s6_yq;
  logic [24:0] s6_xq_q;
  logic [25:0] s6_yq_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      s6_sq[l] = s5_neg_q[l] ? (25'd0 - {1'b0, s5_q_q[l]}) : {1'b0, s5_q_q[l]};
    end
    s6_yq = {s6_sq[1][24], s6_sq[1]} - {{2{flow_q[23]}}, flow_q};
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_xq_q <= s6_sq[0];
      s6_yq_q <= s6_yq;
    end
  end

  // stage 7: floor and fraction, hash products, fraction squared
  logic [31:0] s7_x32, s7_y32;
  logic [31:0] s7_ax_q, s7_ay_q, s7_as_q;
  logic [15:0] s7_ttx_q, s7_tty_q;
  logic [7:0]  s7_fx_q, s7_fy_q;

  assign s7_x32 = {{15{s6_xq_q[24]}}, s6_xq_q[24:8]};
  assign s7_y32 = {{14{s6_yq_q[25]}}, s6_yq_q[25:8]};

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_ax_q  <= s7_x32 * hvn_pkg::HASH_MUL_X;
      s7_ay_q  <= s7_y32 * hvn_pkg::HASH_MUL_Y;
      s7_as_q  <= seed_q * hvn_pkg::HASH_MUL_SEED;
      s7_ttx_q <= s6_xq_q[7:0] * s6_xq_q[7:0];
      s7_tty_q <= s6_yq_q[7:0] * s6_yq_q[7:0];
      s7_fx_q  <= s6_xq_q[7:0];
      s7_fy_q  <= s6_yq_q[7:0];
    end
  end

  // stage 8: corner hash sums, smoothstep
  // corner order: (x,y) (x+1,y) (x,y+1) (x+1,y+1)
  logic [31:0] s8_base;
  logic [25:0] s8_ex, s8_ey;
  logic [31:0] s8_h_q [4];
  logic [7:0]  s8_tx_q, s8_ty_q;

  assign s8_base = s7_ax_q + s7_ay_q + s7_as_q;
  assign s8_ex   = s7_ttx_q * (hvn_pkg::EASE_K - {1'b0, s7_fx_q, 1'b0});
  assign s8_ey   = s7_tty_q * (hvn_pkg::EASE_K - {1'b0, s7_fy_q, 1'b0});

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s8_h_q[0] <= s8_base;
      s8_h_q[1] <= s8_base + hvn_pkg::HASH_MUL_X;
      s8_h_q[2] <= s8_base + hvn_pkg::HASH_MUL_Y;
      s8_h_q[3] <= s8_base + hvn_pkg::HASH_MUL_X + hvn_pkg::HASH_MUL_Y;
      s8_tx_q   <= s8_ex[23:16];
      s8_ty_q   <= s8_ey[23:16];
    end
  end

  // stage 9: xor-shift and mix multiply, only the low 24 bits reach the byte
  logic [31:0] s9_g [4];
  logic [23:0] s9_mix [4];
  logic [23:0] s9_mix_q [4];
  logic [7:0]  s9_tx_q, s9_ty_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      s9_g[c]   = s8_h_q[c] ^ (s8_h_q[c] >> 13);
      s9_mix[c] = s9_g[c][23:0] * hvn_pkg::HASH_MUL_MIX[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      for (int c = 0; c < 4; c++) s9_mix_q[c] <= s9_mix[c];
      s9_tx_q <= s8_tx_q;
      s9_ty_q <= s8_ty_q;
    end
  end

  // stage 10: corner bytes, blend along x
  logic [7:0] s10_n [4];
  logic [7:0] s10_top_q, s10_bot_q, s10_ty_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      s10_n[c] = s9_mix_q[c][7:0] ^ s9_mix_q[c][23:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      s10_top_q <= blend(s10_n[0], s10_n[1], s9_tx_q);
      s10_bot_q <= blend(s10_n[2], s10_n[3], s9_tx_q);
      s10_ty_q  <= s9_ty_q;
    end
  end

  // stage 11: blend along y, output register
  logic [7:0] s11_val_q;

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      s11_val_q <= blend(s10_top_q, s10_bot_q, s10_ty_q);
    end
  end

  assign out_valid_o   = v_q[NStg-1];
  assign noise_value_o = s11_val_q;

`ifndef SYNTHESIS
  // a full pipeline with a stalled output takes no request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !out_ready_i |-> !in_ready_o)
    else $error("request accepted into a full stalled pipeline");

  // an accepted request occupies the first stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted request lost at pipeline entry");

  // reciprocal estimate is never more than two below the true quotient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (s4_rem_q[0] < 16'd46875) && (s4_rem_q[1] < 16'd46875))
    else $error("ppm divide remainder out of correction range");
`endif

endmodule
